/* rtl/sdsh_pkg.sv */
`default_nettype none
package sdsh_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned WAKE_BYTES  = 10;

  typedef enum logic [1:0] {
    OP_REQ  = 2'd0,
    OP_RX   = 2'd1,
    OP_WR   = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RK_INIT  = 2'd0,
    RK_RD1   = 2'd1,
    RK_RDN   = 2'd2,
    RK_WR1   = 2'd3
  } req_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_PRECMD, PH_BUSY, PH_FRAME, PH_RESP, PH_GAPHI, PH_PAD4,
    PH_TOKEN, PH_DATA, PH_CRC, PH_TAIL, PH_WTOKEN, PH_WNEED, PH_WDATA
  } phase_t;

  typedef enum logic [2:0] {
    K_C0, K_C8, K_C55, K_C41, K_C17, K_C18, K_C12, K_C24
  } cmd_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_IDLE  = 3'd1;
  localparam logic [2:0] ST_CMD8     = 3'd2;
  localparam logic [2:0] ST_INIT_TO  = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  request_kind;
    logic [31:0] block_address;
    logic [15:0] block_count;
    logic [9:0]  byte_length;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       fast_clock;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       need_write_byte;
    logic       done_res;
    logic [2:0] status;
  } out_word_t;

  function automatic logic [7:0] cmd_number(cmd_t c);
    case (c)
      K_C0:    return 8'd0;
      K_C8:    return 8'd8;
      K_C55:   return 8'd55;
      K_C41:   return 8'd41;
      K_C17:   return 8'd17;
      K_C18:   return 8'd18;
      K_C12:   return 8'd12;
      default: return 8'd24;
    endcase
  endfunction

  function automatic logic [7:0] cmd_check(cmd_t c);
    case (c)
      K_C0:    return 8'h95;
      K_C8:    return 8'h87;
      K_C55:   return 8'h65;
      K_C41:   return 8'h77;
      K_C18:   return 8'h57;
      default: return 8'h01;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/sdsh_in_if.sv */
`default_nettype none
interface sdsh_in_if import sdsh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/sdsh_out_if.sv */
`default_nettype none
interface sdsh_out_if import sdsh_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/sdsh_front.sv */
`default_nettype none
// Accepts words and pushes them into a 2-entry queue for the back end.
module sdsh_front import sdsh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  sdsh_in_if.sink       in_ch,
  output in_word_t      q_data,
  output logic          q_valid,
  input  wire logic     q_pop
);
  in_word_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  logic push;
  assign push = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_ch.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

/* rtl/sdsh_back.sv */
`default_nettype none
module sdsh_back import sdsh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] timeout_ticks,
  input  wire in_word_t    q_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  sdsh_out_if.source       out_ch
);
  phase_t      phase_r, phase_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [15:0] bl_r, bl_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [15:0] el_r, el_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic        init_r, init_nxt;
  logic        cs_r, cs_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [1:0]  rk_r, rk_nxt;
  logic        ov_r, ov_nxt;
  out_word_t   od_r, od_nxt;

  logic       can_take, has_res;
  out_word_t  o;
  logic [7:0] rx;
  logic       expired;
  logic [31:0] arg;
  logic [2:0]  fi_inc;

  assign can_take = !ov_r || out_ch.ready;
  assign q_pop    = q_valid && can_take;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
  assign rx       = q_data.rx_byte;
  assign expired  = (el_r >= timeout_ticks);
  assign fi_inc   = fi_r + 3'd1;

  always_comb begin
    case (cmd_r)
      K_C8:                 arg = 32'h0000_01AA;
      K_C41:                arg = 32'h4000_0000;
      K_C17, K_C18, K_C24:  arg = addr_r;
      default:              arg = 32'd0;
    endcase
  end

  function automatic logic [7:0] fbyte(logic [2:0] i, cmd_t c, logic [31:0] a);
    case (i)
      3'd0:    return 8'h40 | cmd_number(c);
      3'd1:    return a[31:24];
      3'd2:    return a[23:16];
      3'd3:    return a[15:8];
      3'd4:    return a[7:0];
      default: return cmd_check(c);
    endcase
  endfunction

  always_comb begin
    phase_nxt = phase_r; bc_nxt = bc_r; bl_nxt = bl_r; addr_nxt = addr_r;
    len_nxt = len_r; el_nxt = el_r; fi_nxt = fi_r; init_nxt = init_r;
    cs_nxt = cs_r; cmd_nxt = cmd_r; rk_nxt = rk_r;
    o = '0; has_res = 1'b0;

    if (q_pop) begin
      case (op_t'(q_data.opcode))
        OP_TICK: begin
          if (el_r != 16'hFFFF) el_nxt = el_r + 16'd1;
        end
        OP_REQ: begin
          if (phase_r == PH_IDLE) begin
            has_res = 1'b1;
            rk_nxt = q_data.request_kind;
            addr_nxt = q_data.block_address;
            len_nxt = (q_data.byte_length > 10'(BLOCK_BYTES)) ? 10'(BLOCK_BYTES)
                                                              : q_data.byte_length;
            o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
            case (req_kind_t'(q_data.request_kind))
              RK_INIT: begin
                init_nxt = 1'b0; cs_nxt = 1'b1; bc_nxt = 10'd1; phase_nxt = PH_WAKE;
              end
              RK_RD1: begin
                cs_nxt = 1'b0; cmd_nxt = K_C17; phase_nxt = PH_PRECMD;
              end
              RK_RDN: begin
                len_nxt = 10'(BLOCK_BYTES); bl_nxt = q_data.block_count; cs_nxt = 1'b0;
                cmd_nxt = K_C18; el_nxt = '0; phase_nxt = PH_BUSY;
              end
              default: begin
                cs_nxt = 1'b0; cmd_nxt = K_C24; el_nxt = '0; phase_nxt = PH_BUSY;
              end
            endcase
          end
        end
        OP_WR: begin
          if (phase_r == PH_WNEED) begin
            has_res = 1'b1; phase_nxt = PH_WDATA;
            o.tx_valid = 1'b1; o.tx_byte = q_data.write_byte;
          end
        end
        default: begin
          if (phase_r != PH_IDLE && phase_r != PH_WNEED) begin
            has_res = 1'b1;
            o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
            case (phase_r)
              PH_WAKE: begin
                if (bc_r < 10'(WAKE_BYTES)) bc_nxt = bc_r + 10'd1;
                else begin cs_nxt = 1'b0; cmd_nxt = K_C0; phase_nxt = PH_PRECMD; end
              end
              PH_PRECMD: begin
                el_nxt = '0; phase_nxt = PH_BUSY;
              end
              PH_BUSY: begin
                if (rx == 8'hFF || expired) begin
                  fi_nxt = 3'd0; phase_nxt = PH_FRAME;
                  o.tx_byte = fbyte(3'd0, cmd_r, arg);
                end
              end
              PH_FRAME: begin
                fi_nxt = fi_inc;
                if (fi_inc < 3'd6) o.tx_byte = fbyte(fi_inc, cmd_r, arg);
                else if (cmd_r == K_C55) begin bc_nxt = '0; phase_nxt = PH_PAD4; end
                else if (cmd_r == K_C12) begin bc_nxt = '0; phase_nxt = PH_CRC; end
                else begin el_nxt = '0; phase_nxt = PH_RESP; end
              end
              PH_RESP: begin
                if (rx != 8'hFF || expired) begin
                  // rx stands for the R1 value; a timeout leaves it 0xFF
                  case (cmd_r)
                    K_C0, K_C8: begin
                      if (rx == 8'h01) begin cs_nxt = 1'b1; phase_nxt = PH_GAPHI; end
                      else begin
                        o.tx_valid = 1'b0; o.tx_byte = '0; o.done_res = 1'b1;
                        o.status = (cmd_r == K_C0) ? ST_NO_IDLE : ST_CMD8;
                        cs_nxt = 1'b1; phase_nxt = PH_IDLE;
                      end
                    end
                    K_C41: begin
                      if (rx == 8'h00) begin cs_nxt = 1'b1; phase_nxt = PH_TAIL; end
                      else if (expired) begin
                        o.tx_valid = 1'b0; o.tx_byte = '0; o.done_res = 1'b1;
                        o.status = ST_INIT_TO; cs_nxt = 1'b1; phase_nxt = PH_IDLE;
                      end else begin
                        cs_nxt = 1'b0; cmd_nxt = K_C55; phase_nxt = PH_PRECMD;
                      end
                    end
                    default: begin
                      if (rx == 8'h00) begin
                        if (cmd_r == K_C17) phase_nxt = PH_TOKEN;
                        else if (cmd_r == K_C18) begin
                          if (bl_r != '0) phase_nxt = PH_TOKEN;
                          else begin cmd_nxt = K_C12; el_nxt = '0; phase_nxt = PH_BUSY; end
                        end else begin
                          phase_nxt = PH_WTOKEN; o.tx_byte = 8'hFE;
                        end
                      end else begin
                        o.tx_valid = 1'b0; o.tx_byte = '0; o.done_res = 1'b1;
                        o.status = ST_REJECT; cs_nxt = 1'b1; phase_nxt = PH_IDLE;
                      end
                    end
                  endcase
                end
              end
              PH_GAPHI: begin
                cs_nxt = 1'b0;
                if (cmd_r == K_C0) begin cmd_nxt = K_C8; el_nxt = '0; phase_nxt = PH_BUSY; end
                else begin cmd_nxt = K_C55; phase_nxt = PH_PRECMD; end
              end
              PH_PAD4: begin
                bc_nxt = bc_r + 10'd1;
                if (bc_r + 10'd1 >= 10'd4) begin
                  cmd_nxt = K_C41; el_nxt = '0; phase_nxt = PH_BUSY;
                end
              end
              PH_TOKEN: begin
                if (rx == 8'hFE) begin bc_nxt = '0; phase_nxt = PH_DATA; end
              end
              PH_DATA: begin
                if (bc_r < len_r) begin o.read_valid = 1'b1; o.read_byte = rx; end
                bc_nxt = bc_r + 10'd1;
                if (bc_r == 10'(BLOCK_BYTES - 1)) begin
                  if (rk_r == 2'(RK_RDN)) begin
                    bl_nxt = bl_r - 16'd1;
                    if (bl_r != 16'd1) phase_nxt = PH_TOKEN;
                    else begin cmd_nxt = K_C12; el_nxt = '0; phase_nxt = PH_BUSY; end
                  end else begin bc_nxt = '0; phase_nxt = PH_CRC; end
                end
              end
              PH_CRC: begin
                bc_nxt = bc_r + 10'd1;
                if (bc_r != 10'd0) begin cs_nxt = 1'b1; phase_nxt = PH_TAIL; end
              end
              PH_TAIL: begin
                if (rk_r == 2'(RK_INIT)) init_nxt = 1'b1;
                o.tx_valid = 1'b0; o.tx_byte = '0; o.done_res = 1'b1; o.status = ST_OK;
                cs_nxt = 1'b1; phase_nxt = PH_IDLE;
              end
              PH_WTOKEN: begin
                bc_nxt = '0;
                if (len_r != '0) begin
                  phase_nxt = PH_WNEED; o.tx_valid = 1'b0; o.tx_byte = '0;
                  o.need_write_byte = 1'b1;
                end else begin
                  phase_nxt = PH_WDATA; o.tx_byte = 8'h00;
                end
              end
              default: begin
                bc_nxt = bc_r + 10'd1;
                if (bc_r == 10'(BLOCK_BYTES - 1)) begin bc_nxt = '0; phase_nxt = PH_CRC; end
                else if (bc_r + 10'd1 < len_r) begin
                  phase_nxt = PH_WNEED; o.tx_valid = 1'b0; o.tx_byte = '0;
                  o.need_write_byte = 1'b1;
                end else o.tx_byte = 8'h00;
              end
            endcase
          end
        end
      endcase
    end
    o.chip_select = cs_nxt;
    o.fast_clock  = init_nxt;
    ov_nxt = has_res ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
    od_nxt = has_res ? o : od_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bc_r <= '0; bl_r <= '0; addr_r <= '0; len_r <= '0;
      el_r <= '0; fi_r <= '0; init_r <= 1'b0; cs_r <= 1'b1; cmd_r <= K_C0;
      rk_r <= '0; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; bc_r <= bc_nxt; bl_r <= bl_nxt; addr_r <= addr_nxt;
      len_r <= len_nxt; el_r <= el_nxt; fi_r <= fi_nxt; init_r <= init_nxt;
      cs_r <= cs_nxt; cmd_r <= cmd_nxt; rk_r <= rk_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end
endmodule
`default_nettype wire

/* rtl/sd_spi_host_sequencer.sv */
`default_nettype none
// SD SPI-mode host sequencer: one word accepted per cycle sustained while
// the output is not stalled. A word is registered in the 2-entry queue, and
// the sequencer then registers its result in its output register.
// Ticks and ignored words give no result word.
// Synchronous active-low reset: idle, card deselected, timeout 300 ticks.
module sd_spi_host_sequencer import sdsh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sdsh_in_if.sink          in_ch,
  sdsh_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  logic [15:0] timeout_r;
  in_word_t    q_data;
  logic        q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= 16'd300;
    else if (cfg_we) timeout_r <= cfg_wdata;
  end

  sdsh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  sdsh_back u_back (
    .clk(clk), .rst_n(rst_n), .timeout_ticks(timeout_r),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire
